>>> hdl/sacr_pkg.sv
package sacr_pkg;

  localparam int LINE_BYTES  = 64;
  localparam int WAY_COUNT   = 4;
  localparam int SET_COUNT   = 512;
  localparam int SIG_BITS    = 10;
  localparam int ADDR_BITS   = 48;
  localparam int TIME_BITS   = 48;
  localparam int USE_BITS    = 32;
  localparam int CNT_BITS    = 5;

  localparam int OFF_W       = $clog2(LINE_BYTES);
  localparam int SET_W       = $clog2(SET_COUNT);
  localparam int TAG_W       = ADDR_BITS - OFF_W - SET_W;
  localparam int WAY_W       = $clog2(WAY_COUNT);
  localparam int SIG_ENTRIES = 1 << SIG_BITS;
  localparam int CLR_DEPTH   = (SET_COUNT > SIG_ENTRIES) ? SET_COUNT : SIG_ENTRIES;
  localparam int CLR_W       = $clog2(CLR_DEPTH);

  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

  localparam logic [1:0] POLICY_LRU  = 2'd0;
  localparam logic [1:0] POLICY_LFU  = 2'd1;
  localparam logic [1:0] POLICY_SHIP = 2'd2;

  typedef struct packed {
    logic [ADDR_BITS-1:0] address;
    logic                 is_store;
    logic [ADDR_BITS-1:0] pc;
    logic [TIME_BITS-1:0] stamp;
  } in_word_t;

  typedef struct packed {
    logic                 hit;
    logic                 evicted;
    logic [ADDR_BITS-1:0] evict_address;
  } out_word_t;

  typedef struct packed {
    logic [TAG_W-1:0]     tag;
    logic                 valid;
    logic                 dirty;
    logic [TIME_BITS-1:0] touch;
    logic [USE_BITS-1:0]  use_cnt;
    logic                 reused;
    logic [SIG_BITS-1:0]  sig;
  } way_t;

  typedef way_t [WAY_COUNT-1:0] row_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic clear;
    logic start;
    logic lookup;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } sts_t;

endpackage

>>> hdl/sacr_ctrl.sv
module sacr_ctrl
  import sacr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd,
  output logic in_stall,
  output logic out_valid
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_busy;

  assign out_busy = out_valid_r && out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (sts.clear_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_LOOKUP;
      ST_LOOKUP: state_nxt = ST_UPDATE;
      ST_UPDATE: if (!out_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_CLEAR:  cmd.clear = 1'b1;
      ST_IDLE:   cmd.start = in_valid;
      ST_LOOKUP: cmd.lookup = 1'b1;
      ST_UPDATE: cmd.update = !out_busy;
      default:   cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_busy || cmd.update;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> hdl/sacr_datapath.sv
module sacr_datapath
  import sacr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  in_word_t   in_word,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  output out_word_t  out_word
);

  row_t                row_mem [SET_COUNT];
  logic [CNT_BITS-1:0] cnt_mem [SIG_ENTRIES];

  logic [1:0]          policy_r;
  logic [CLR_W-1:0]    clr_r;
  in_word_t            req_r;
  row_t                row_rd_r;
  logic [CNT_BITS-1:0] cnt_pc_rd_r;
  logic [CNT_BITS-1:0] cnt_line_rd_r;
  logic                hit_r, evict_r, dec_r;
  logic [WAY_W-1:0]    way_r;
  logic [SIG_BITS-1:0] lsig_r;
  out_word_t           out_word_r;

  // lookup-stage signals
  logic [SET_W-1:0]    req_set;
  logic [TAG_W-1:0]    req_tag;
  logic [SIG_BITS-1:0] req_sig;
  logic                hit_c, free_c;
  logic [WAY_W-1:0]    hit_way_c, free_way_c, vic_way_c, way_c;
  logic [SIG_BITS-1:0] lsig_c;

  // update-stage signals
  row_t                row_wr;
  way_t                old_way, new_way;
  logic [CNT_BITS-1:0] cnt_line_new, cnt_fill;
  logic                cnt_wr;
  logic                is_ship;
  row_t                clr_row;

  assign req_set = req_r.address[OFF_W +: SET_W];
  assign req_tag = req_r.address[ADDR_BITS-1 -: TAG_W];
  assign req_sig = req_r.pc[SIG_BITS-1:0];
  assign is_ship = (policy_r == POLICY_SHIP);

  always_comb begin
    for (int w = 0; w < WAY_COUNT; w++) begin
      clr_row[w]     = '0;
      clr_row[w].tag = '1;
    end
  end

  // tag match, first free way, and victim by lowest touch time or use count
  always_comb begin
    hit_c      = 1'b0;
    free_c     = 1'b0;
    hit_way_c  = '0;
    free_way_c = '0;
    vic_way_c  = '0;
    for (int w = WAY_COUNT - 1; w >= 0; w--) begin
      if (row_rd_r[w].valid && row_rd_r[w].tag == req_tag) begin
        hit_c     = 1'b1;
        hit_way_c = WAY_W'(w);
      end
      if (!row_rd_r[w].valid) begin
        free_c     = 1'b1;
        free_way_c = WAY_W'(w);
      end
    end
    for (int w = 1; w < WAY_COUNT; w++) begin
      if (policy_r == POLICY_LFU) begin
        if (row_rd_r[w].use_cnt < row_rd_r[vic_way_c].use_cnt) vic_way_c = WAY_W'(w);
      end else begin
        if (row_rd_r[w].touch < row_rd_r[vic_way_c].touch) vic_way_c = WAY_W'(w);
      end
    end
    way_c  = hit_c ? hit_way_c : (free_c ? free_way_c : vic_way_c);
    lsig_c = row_rd_r[way_c].sig;
  end

  // counter and line write-back
  always_comb begin
    old_way = row_rd_r[way_r];
    if (hit_r) begin
      cnt_line_new = (cnt_line_rd_r != CNT_MAX) ? cnt_line_rd_r + 1'b1 : cnt_line_rd_r;
    end else begin
      cnt_line_new = (cnt_line_rd_r != '0) ? cnt_line_rd_r - 1'b1 : cnt_line_rd_r;
    end
    cnt_wr   = hit_r || dec_r;
    cnt_fill = (dec_r && lsig_r == req_sig) ? cnt_line_new : cnt_pc_rd_r;

    new_way = old_way;
    if (hit_r) begin
      new_way.reused = 1'b1;
      new_way.touch  = req_r.stamp;
      if (old_way.use_cnt != '1) new_way.use_cnt = old_way.use_cnt + 1'b1;
      if (req_r.is_store) new_way.dirty = 1'b1;
    end else begin
      new_way.tag    = req_tag;
      new_way.valid  = 1'b1;
      new_way.reused = 1'b0;
      new_way.dirty  = req_r.is_store;
      if (is_ship) begin
        new_way.sig     = req_sig;
        new_way.use_cnt = '0;
        new_way.touch   = (cnt_fill != '0) ? req_r.stamp : '0;
      end else begin
        new_way.touch   = req_r.stamp;
        new_way.use_cnt = USE_BITS'(1);
      end
    end
    row_wr        = row_rd_r;
    row_wr[way_r] = new_way;
  end

  always_ff @(posedge clk) begin
    if (cmd.clear && {1'b0, clr_r} < (CLR_W+1)'(SET_COUNT)) row_mem[clr_r[SET_W-1:0]] <= clr_row;
    else if (cmd.update) row_mem[req_set] <= row_wr;
    if (cmd.start) row_rd_r <= row_mem[in_word.address[OFF_W +: SET_W]];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear && {1'b0, clr_r} < (CLR_W+1)'(SIG_ENTRIES))
      cnt_mem[clr_r[SIG_BITS-1:0]] <= '0;
    else if (cmd.update && cnt_wr) cnt_mem[lsig_r] <= cnt_line_new;
    if (cmd.start) cnt_pc_rd_r <= cnt_mem[in_word.pc[SIG_BITS-1:0]];
    else if (cmd.lookup) cnt_line_rd_r <= cnt_mem[lsig_c];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) req_r <= in_word;
    if (cmd.lookup) begin
      hit_r   <= hit_c;
      evict_r <= !hit_c && !free_c;
      dec_r   <= !hit_c && !free_c && !row_rd_r[vic_way_c].reused;
      way_r   <= way_c;
      lsig_r  <= lsig_c;
    end
    if (cmd.update) begin
      out_word_r.hit           <= hit_r;
      out_word_r.evicted       <= evict_r;
      out_word_r.evict_address <= evict_r ?
          ADDR_BITS'({old_way.tag, req_set, OFF_W'(0)}) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POLICY_LRU;
      clr_r    <= '0;
    end else begin
      if (cfg_wr_en) policy_r <= cfg_wr_data;
      if (cmd.clear) clr_r <= clr_r + 1'b1;
    end
  end

  assign sts.clear_last = (clr_r == CLR_W'(CLR_DEPTH - 1));
  assign out_word       = out_word_r;

endmodule

>>> hdl/set_assoc_cache_replacement_unit.sv
// 4-way set-associative cache directory with LRU, LFU or SHiP victim choice.
// Each input word carries an address, a store flag, a pc and a timestamp; one
// output word comes back per input word with hit, evicted and the line address
// of the evicted line (zero when nothing was evicted). After reset the block
// runs a clearing pass over the set array and the signature counter table,
// holding in_stall high; policy writes are taken throughout.
// Each item is handled in order: a read of the set row and the pc's counter,
// then a tag compare, victim pick and read of the line's counter, then a
// write-back of both memories and a load of the output register.
// Only one item is in flight; a waiting output word holds the write-back.
module set_assoc_cache_replacement_unit
  import sacr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_word,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_word,
  // policy register
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  // sequencing of clear, read, lookup and write-back
  sacr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  // set and counter memories, victim logic and output register
  sacr_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_word     (in_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_word    (out_word)
  );

endmodule

>>> hdl/sacr_checker.sv
module sacr_checker
  import sacr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word dropped or changed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while one is in flight");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_word.hit && out_word.evicted))
    else $error("hit reported with an eviction");

  a_evict_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.evicted |-> out_word.evict_address == '0)
    else $error("evict address nonzero without eviction");

endmodule

bind set_assoc_cache_replacement_unit sacr_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
